// ----- rtl/vpac_pkg.sv -----
// Package: shared types and constants for the video port access controller.
`default_nettype none
package vpac_pkg;

    localparam int PALETTE_ENTRIES = 64;
    localparam int SCROLL_ENTRIES  = 40;
    localparam int REGISTER_COUNT  = 24;

    localparam int CRAM_AW = $clog2(PALETTE_ENTRIES);
    localparam int SRAM_AW = $clog2(SCROLL_ENTRIES);
    localparam int REG_AW  = $clog2(REGISTER_COUNT);
    localparam int VRAM_AW = 16;
    localparam int CNT_W   = 17;

    localparam logic [2:0] KIND_CTRL   = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_READ   = 3'd2;
    localparam logic [2:0] KIND_STATUS = 3'd3;
    localparam logic [2:0] KIND_HV     = 3'd4;
    localparam logic [2:0] KIND_LINE   = 3'd5;

    localparam logic [3:0] CODE_CRAM_WR = 4'h3;
    localparam logic [3:0] CODE_SRAM_WR = 4'h5;
    localparam logic [3:0] CODE_CRAM_RD = 4'h8;
    localparam logic [3:0] CODE_SRAM_RD = 4'h4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WR_LO,
        S_FILL,
        S_RD_LO,
        S_RD_FIN,
        S_CP_RD,
        S_CP_WR,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_CTRL,
        OP_PORT,
        OP_CRAM_WR,
        OP_SRAM_WR,
        OP_WR_HI,
        OP_WR_LO,
        OP_FILL_STEP,
        OP_RD_HI,
        OP_RD_LO,
        OP_RD_FIN,
        OP_CP_RD,
        OP_CP_WR,
        OP_PUSH
    } t_op;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] code_lo;
        logic       fill_armed;
        logic       copy_go;
        logic       count_last;
        logic       clear_last;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

// ----- rtl/vpac_ctrl.sv -----
// Controller: sequences clearing, port accesses and DMA loops.
`default_nettype none
module vpac_ctrl import vpac_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_op   o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.kind)
                    KIND_CTRL: begin
                        o_op    = OP_CTRL;
                        n_state = i_stat.copy_go ? S_CP_RD : S_DONE;
                    end
                    KIND_WRITE: begin
                        if (i_stat.fill_armed) begin
                            o_op    = OP_WR_HI;
                            n_state = S_WR_LO;
                        end else if (i_stat.code_lo == CODE_CRAM_WR) begin
                            o_op    = OP_CRAM_WR;
                            n_state = S_DONE;
                        end else if (i_stat.code_lo == CODE_SRAM_WR) begin
                            o_op    = OP_SRAM_WR;
                            n_state = S_DONE;
                        end else begin
                            o_op    = OP_WR_HI;
                            n_state = S_WR_LO;
                        end
                    end
                    KIND_READ: begin
                        o_op = OP_RD_HI;
                        if (i_stat.code_lo inside {CODE_CRAM_RD, CODE_SRAM_RD}) begin
                            n_state = S_RD_FIN;
                        end else begin
                            n_state = S_RD_LO;
                        end
                    end
                    default: begin
                        o_op    = OP_PORT;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WR_LO: begin
                o_op    = OP_WR_LO;
                n_state = i_stat.fill_armed ? S_FILL : S_DONE;
            end
            S_FILL: begin
                o_op = OP_FILL_STEP;
                if (i_stat.count_last) n_state = S_DONE;
            end
            S_RD_LO: begin
                o_op    = OP_RD_LO;
                n_state = S_RD_FIN;
            end
            S_RD_FIN: begin
                o_op    = OP_RD_FIN;
                n_state = S_DONE;
            end
            S_CP_RD: begin
                o_op    = OP_CP_RD;
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                o_op    = OP_CP_WR;
                n_state = i_stat.count_last ? S_DONE : S_CP_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_op    = OP_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/vpac_dp.sv -----
// Datapath: memories, register file, port state and output register.
`default_nettype none
module vpac_dp import vpac_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_op         i_op,
    output t_stat       o_stat,
    input  wire  [2:0]  i_kind,
    input  wire  [15:0] i_value,
    input  wire  [8:0]  i_line,
    input  wire         i_ready,
    output logic        o_valid,
    output logic [15:0] o_read_value,
    output logic        o_hblank_irq,
    output logic        o_vblank_irq,
    output logic        o_palette_write,
    output logic [5:0]  o_palette_index,
    output logic [11:0] o_palette_color
);

    logic [7:0]  r_vram [2**VRAM_AW];
    logic [11:0] r_cram [PALETTE_ENTRIES];
    logic [9:0]  r_sram [SCROLL_ENTRIES];
    logic [7:0]  r_vq;
    logic [11:0] r_cq;
    logic [9:0]  r_sq;

    logic [7:0]  r_regs [REGISTER_COUNT];
    logic [15:0] r_addr;
    logic [5:0]  r_code;
    logic        r_second;
    logic        r_fill;
    logic        r_vint;
    logic        r_vb;
    logic        r_hb;
    logic [7:0]  r_hcnt;
    logic [8:0]  r_cur_line;
    logic [VRAM_AW-1:0] r_clr;
    logic [CNT_W-1:0]   r_cnt;
    logic [15:0] r_src;

    logic [2:0]  r_kind;
    logic [15:0] r_value;
    logic [8:0]  r_line;
    logic [7:0]  r_hi;

    logic [15:0] r_rd;
    logic        r_hirq;
    logic        r_virq;
    logic        r_pw;
    logic [5:0]  r_pidx;
    logic [11:0] r_pcol;
    logic        r_ovalid;

    logic [VRAM_AW-1:0] v_wa;
    logic [VRAM_AW-1:0] v_ra;
    logic [7:0]         v_wd;
    logic               v_we;
    logic [CRAM_AW-1:0] c_idx;
    logic [SRAM_AW-1:0] s_idx;
    logic               s_in;
    logic [15:0]        bumped;
    logic [CNT_W-1:0]   len;
    logic [4:0]         reg_sel;
    logic [5:0]         code2;
    logic [8:0]         active;
    logic [15:0]        rd_mem;

    assign c_idx   = r_addr[CRAM_AW:1];
    assign s_in    = ({1'b0, r_addr[15:1]} < 16'(SCROLL_ENTRIES));
    assign s_idx   = s_in ? r_addr[SRAM_AW:1] : '0;
    assign bumped  = r_addr + {8'd0, r_regs[15]};
    assign len     = ({r_regs[20], r_regs[19]} == 16'd0) ? 17'h10000
                                                          : {1'b0, r_regs[20], r_regs[19]};
    assign reg_sel = r_value[12:8];
    assign code2   = {r_value[7:4], r_code[1:0]};
    assign active  = r_regs[1][3] ? 9'd240 : 9'd224;

    always_comb begin
        case (r_code[3:0])
            CODE_CRAM_RD: rd_mem = {4'd0, r_cq};
            CODE_SRAM_RD: rd_mem = s_in ? {6'd0, r_sq} : 16'd0;
            default:      rd_mem = {r_hi, r_vq};
        endcase
    end

    always_comb begin
        v_we = 1'b0;
        v_wa = r_addr;
        v_wd = r_value[15:8];
        v_ra = r_addr;
        case (i_op)
            OP_CLEAR: begin
                v_we = 1'b1;
                v_wa = r_clr;
                v_wd = 8'd0;
            end
            OP_WR_HI: begin
                v_we = 1'b1;
                v_wa = {r_addr[15:1], 1'b0};
                v_wd = r_addr[0] ? r_value[7:0] : r_value[15:8];
            end
            OP_WR_LO: begin
                v_we = 1'b1;
                v_wa = {r_addr[15:1], 1'b1};
                v_wd = r_addr[0] ? r_value[15:8] : r_value[7:0];
            end
            OP_FILL_STEP: begin
                v_we = 1'b1;
                v_wa = r_addr ^ 16'd1;
                v_wd = r_value[15:8];
            end
            OP_CP_WR: begin
                v_we = 1'b1;
                v_wa = r_addr;
                v_wd = r_vq;
            end
            OP_RD_HI: v_ra = {r_addr[15:1], 1'b0};
            OP_RD_LO: v_ra = {r_addr[15:1], 1'b1};
            OP_CP_RD: v_ra = r_src;
            default: begin
                v_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_vram[v_wa] <= v_wd;
        r_vq <= r_vram[v_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_CLEAR) begin
            r_cram[r_clr[CRAM_AW-1:0]] <= 12'd0;
        end else if (i_op == OP_CRAM_WR) begin
            r_cram[c_idx] <= r_value[11:0] & 12'hEEE;
        end
        r_cq <= r_cram[c_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_CLEAR) begin
            if ({10'd0, r_clr[5:0]} < 16'(SCROLL_ENTRIES)) begin
                r_sram[r_clr[SRAM_AW-1:0]] <= 10'd0;
            end
        end else if (i_op == OP_SRAM_WR && s_in) begin
            r_sram[s_idx] <= r_value[9:0];
        end
        r_sq <= r_sram[s_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REGISTER_COUNT; k++) begin
                r_regs[k] <= (k == 15) ? 8'd2 : 8'd0;
            end
            r_addr     <= '0;
            r_code     <= '0;
            r_second   <= 1'b0;
            r_fill     <= 1'b0;
            r_vint     <= 1'b0;
            r_vb       <= 1'b0;
            r_hb       <= 1'b0;
            r_hcnt     <= '0;
            r_cur_line <= '0;
            r_clr      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_op == OP_PUSH) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_op)
                OP_CLEAR: r_clr <= r_clr + 1'b1;
                OP_CTRL: begin
                    if (!r_second) begin
                        if (r_value[15:14] == 2'b10) begin
                            if ({3'd0, reg_sel} < 8'(REGISTER_COUNT)) begin
                                r_regs[reg_sel[REG_AW-1:0]] <= r_value[7:0];
                            end
                            r_code <= '0;
                        end else begin
                            r_addr   <= {r_addr[15:14], r_value[13:0]};
                            r_code   <= {r_code[5:2], r_value[15:14]};
                            r_second <= 1'b1;
                        end
                    end else begin
                        r_addr   <= {r_value[1:0], r_addr[13:0]};
                        r_code   <= code2;
                        r_second <= 1'b0;
                        if (code2[5] && r_regs[1][4] && r_regs[23][7] && !r_regs[23][6]) begin
                            r_fill <= 1'b1;
                        end
                    end
                end
                OP_CRAM_WR, OP_SRAM_WR, OP_RD_FIN: begin
                    r_second <= 1'b0;
                    r_addr   <= bumped;
                end
                OP_WR_HI, OP_RD_HI: r_second <= 1'b0;
                OP_WR_LO: r_addr <= bumped;
                OP_FILL_STEP: begin
                    r_addr <= bumped;
                    if (r_cnt == 17'd1) r_fill <= 1'b0;
                end
                OP_CP_WR: r_addr <= bumped;
                OP_PORT: begin
                    case (r_kind)
                        KIND_STATUS: begin
                            r_second <= 1'b0;
                            r_vint   <= 1'b0;
                            r_hb     <= !r_hb;
                        end
                        KIND_LINE: begin
                            r_cur_line <= r_line;
                            if (r_line < active) begin
                                if (r_hcnt == 8'd0) begin
                                    r_hcnt <= r_regs[10];
                                end else begin
                                    r_hcnt <= r_hcnt - 1'b1;
                                end
                            end else begin
                                r_hcnt <= r_regs[10];
                                if (r_line == active) r_vint <= 1'b1;
                            end
                            if (r_line == 9'd0) begin
                                r_vb <= 1'b0;
                            end else if (r_line == active) begin
                                r_vb <= 1'b1;
                            end
                        end
                        default: begin
                            r_second <= r_second;
                        end
                    endcase
                end
                default: begin
                    r_clr <= r_clr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_kind  <= i_kind;
                r_value <= i_value;
                r_line  <= i_line;
                r_rd    <= '0;
                r_hirq  <= 1'b0;
                r_virq  <= 1'b0;
                r_pw    <= 1'b0;
                r_pidx  <= '0;
                r_pcol  <= '0;
            end
            OP_CTRL: begin
                r_cnt <= len;
                r_src <= {r_regs[22], r_regs[21]};
            end
            OP_WR_HI: r_cnt <= len;
            OP_FILL_STEP, OP_CP_WR: begin
                r_cnt <= r_cnt - 1'b1;
                r_src <= r_src + 16'd1;
            end
            OP_CRAM_WR: begin
                r_pw   <= 1'b1;
                r_pidx <= 6'(c_idx);
                r_pcol <= r_value[11:0] & 12'hEEE;
            end
            OP_RD_LO: r_hi <= r_vq;
            OP_RD_FIN: r_rd <= rd_mem;
            OP_PORT: begin
                case (r_kind)
                    KIND_STATUS: begin
                        r_rd <= {8'h36, r_vint, 3'd0, r_vb, r_hb, 2'd0};
                    end
                    KIND_HV: begin
                        r_rd <= {r_cur_line[7:0], !r_hb, 7'd0};
                    end
                    KIND_LINE: begin
                        if (r_line < active) begin
                            r_hirq <= (r_hcnt == 8'd0) && r_regs[0][4];
                        end else begin
                            r_virq <= (r_line == active) && r_regs[1][5];
                        end
                    end
                    default: begin
                        r_rd <= '0;
                    end
                endcase
            end
            OP_PUSH: begin
                o_read_value    <= r_rd;
                o_hblank_irq    <= r_hirq;
                o_vblank_irq    <= r_virq;
                o_palette_write <= r_pw;
                o_palette_index <= r_pidx;
                o_palette_color <= r_pcol;
            end
            default: begin
                r_hi <= r_hi;
            end
        endcase
    end

    assign o_valid           = r_ovalid;
    assign o_stat.kind       = r_kind;
    assign o_stat.code_lo    = r_code[3:0];
    assign o_stat.fill_armed = r_fill;
    assign o_stat.copy_go    = r_second && (r_kind == KIND_CTRL) && code2[5] && r_regs[1][4]
                               && r_regs[23][7] && r_regs[23][6];
    assign o_stat.count_last = (r_cnt == 17'd1);
    assign o_stat.clear_last = (r_clr == {VRAM_AW{1'b1}});
    assign o_stat.out_free   = !r_ovalid || i_ready;

endmodule
`default_nettype wire

// ----- rtl/video_port_access_controller.sv -----
// Control, status, HV, line and colour/scroll writes go from S_EXEC to S_DONE; VRAM writes
// pass S_WR_LO, colour/scroll reads S_RD_FIN, and VRAM reads S_RD_LO then S_RD_FIN.
// Fill DMA writes one byte per step; copy DMA reads then writes each byte (single VRAM port).
// One item at a time, taken only in S_IDLE; the next item is taken while a result waits.
// After reset a pass over all VRAM addresses zeroes the memories; no item is taken meanwhile.
`default_nettype none
module video_port_access_controller import vpac_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_kind,
    input  wire  [15:0] i_value,
    input  wire  [8:0]  i_line,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [15:0] o_read_value,
    output logic        o_hblank_irq,
    output logic        o_vblank_irq,
    output logic        o_palette_write,
    output logic [5:0]  o_palette_index,
    output logic [11:0] o_palette_color
);

    t_op   op;
    t_stat stat;

    vpac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_op    (op)
    );

    vpac_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_stat          (stat),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .i_line          (i_line),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_read_value    (o_read_value),
        .o_hblank_irq    (o_hblank_irq),
        .o_vblank_irq    (o_vblank_irq),
        .o_palette_write (o_palette_write),
        .o_palette_index (o_palette_index),
        .o_palette_color (o_palette_color)
    );

endmodule
`default_nettype wire

// ----- tb/video_port_access_controller_test.sv -----
// Testbench: directed and randomized port traffic for the video port access controller, checked by a scoreboard.
`timescale 1ns / 1ps
module video_port_access_controller_test import vpac_pkg::*; ();

    localparam logic [5:0] CODE_VRAM_RD = 6'h00;
    localparam logic [5:0] CODE_VRAM_WR = 6'h01;
    localparam logic [5:0] CODE_DMA     = 6'h20;
    localparam logic [2:0] KIND_SPARE0  = 3'd6;
    localparam logic [2:0] KIND_SPARE1  = 3'd7;
    localparam int REG_SETUP0 = 0;
    localparam int REG_SETUP1 = 1;
    localparam int REG_HINT  = 10;
    localparam int REG_INCR  = 15;
    localparam int REG_LEN_LO = 19;
    localparam int REG_LEN_HI = 20;
    localparam int REG_SRC_LO = 21;
    localparam int REG_SRC_HI = 22;
    localparam int REG_DMA    = 23;

    typedef struct packed {
        logic [15:0] read_value;
        logic        hblank_irq;
        logic        vblank_irq;
        logic        palette_write;
        logic [5:0]  palette_index;
        logic [11:0] palette_color;
    } t_port_result;

    class port_scoreboard;
        logic [7:0]  vram [65536];
        logic [11:0] cram [PALETTE_ENTRIES];
        logic [9:0]  sram [SCROLL_ENTRIES];
        logic [7:0]  regs [REGISTER_COUNT];
        logic [15:0] addr;
        logic [5:0]  code;
        bit          second_word, fill_armed, vint_flag, vblank, hblank;
        logic [7:0]  hint_count;
        logic [8:0]  cur_line;
        t_port_result expected_q[$];
        int          errors;
        int          checked;

        function new();
            foreach (vram[i]) vram[i] = '0;
            foreach (cram[i]) cram[i] = '0;
            foreach (sram[i]) sram[i] = '0;
            foreach (regs[i]) regs[i] = '0;
            regs[REG_INCR] = 8'd2;
            addr = '0; code = '0;
            second_word = 0; fill_armed = 0; vint_flag = 0; vblank = 0; hblank = 0;
            hint_count = '0; cur_line = '0;
            errors = 0; checked = 0;
        endfunction

        function void advance();
            addr = addr + 16'(regs[REG_INCR]);
        endfunction

        function int xfer_len();
            int n;
            n = {regs[REG_LEN_HI], regs[REG_LEN_LO]};
            return (n == 0) ? 65536 : n;
        endfunction

        function void put_word(logic [15:0] a, logic [15:0] w);
            logic [15:0] b;
            b = {a[15:1], 1'b0};
            if (a[0]) begin
                vram[b] = w[7:0];
                vram[16'(b + 1)] = w[15:8];
            end else begin
                vram[b] = w[15:8];
                vram[16'(b + 1)] = w[7:0];
            end
        endfunction

        function void start_dma();
            logic [15:0] src;
            int n;
            if (!code[5] || !regs[REG_SETUP1][4] || !regs[REG_DMA][7]) return;
            if (!regs[REG_DMA][6]) begin
                fill_armed = 1;
                return;
            end
            n = xfer_len();
            src = {regs[REG_SRC_HI], regs[REG_SRC_LO]};
            repeat (n) begin
                vram[addr] = vram[src];
                src = src + 16'd1;
                advance();
            end
        endfunction

        function void note_item(logic [2:0] k, logic [15:0] v, logic [8:0] ln);
            t_port_result r;
            int idx, n, active;
            logic [15:0] b;
            r = '0;
            case (k)
                KIND_CTRL: begin
                    if (!second_word) begin
                        if (v[15:14] == 2'b10) begin
                            idx = v[12:8];
                            if (idx < REGISTER_COUNT) regs[idx] = v[7:0];
                            code = '0;
                        end else begin
                            addr = {addr[15:14], v[13:0]};
                            code = {code[5:2], v[15:14]};
                            second_word = 1;
                        end
                    end else begin
                        addr = {v[1:0], addr[13:0]};
                        code = {v[7:4], code[1:0]};
                        second_word = 0;
                        start_dma();
                    end
                end
                KIND_WRITE: begin
                    second_word = 0;
                    if (fill_armed) begin
                        n = xfer_len();
                        put_word(addr, v);
                        advance();
                        repeat (n) begin
                            vram[addr ^ 16'd1] = v[15:8];
                            advance();
                        end
                        fill_armed = 0;
                    end else begin
                        if (code[3:0] == CODE_CRAM_WR) begin
                            idx = (addr >> 1) % PALETTE_ENTRIES;
                            cram[idx] = v[11:0] & 12'hEEE;
                            r.palette_write = 1;
                            r.palette_index = 6'(idx);
                            r.palette_color = v[11:0] & 12'hEEE;
                        end else if (code[3:0] == CODE_SRAM_WR) begin
                            idx = addr >> 1;
                            if (idx < SCROLL_ENTRIES) sram[idx] = v[9:0];
                        end else begin
                            put_word(addr, v);
                        end
                        advance();
                    end
                end
                KIND_READ: begin
                    second_word = 0;
                    if (code[3:0] == CODE_CRAM_RD) begin
                        r.read_value = 16'(cram[(addr >> 1) % PALETTE_ENTRIES]);
                    end else if (code[3:0] == CODE_SRAM_RD) begin
                        idx = addr >> 1;
                        r.read_value = (idx < SCROLL_ENTRIES) ? 16'(sram[idx]) : 16'd0;
                    end else begin
                        b = {addr[15:1], 1'b0};
                        r.read_value = {vram[b], vram[16'(b + 1)]};
                    end
                    advance();
                end
                KIND_STATUS: begin
                    second_word = 0;
                    r.read_value = 16'h3600 | (vint_flag ? 16'h0080 : 16'h0)
                                 | (vblank ? 16'h0008 : 16'h0) | (hblank ? 16'h0004 : 16'h0);
                    vint_flag = 0;
                    hblank = !hblank;
                end
                KIND_HV: begin
                    r.read_value = {cur_line[7:0], hblank ? 8'h00 : 8'h80};
                end
                KIND_LINE: begin
                    active = regs[REG_SETUP1][3] ? 240 : 224;
                    cur_line = ln;
                    if (ln < active) begin
                        if (hint_count == 0) begin
                            hint_count = regs[REG_HINT];
                            r.hblank_irq = regs[REG_SETUP0][4];
                        end else begin
                            hint_count = hint_count - 8'd1;
                        end
                    end else begin
                        hint_count = regs[REG_HINT];
                        if (ln == active) begin
                            vblank = 1;
                            vint_flag = 1;
                            r.vblank_irq = regs[REG_SETUP1][5];
                        end
                    end
                    if (ln == 0) vblank = 0;
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(t_port_result got);
            t_port_result e;
            if (expected_q.size() == 0) begin
                $error("result with no item pending: %h", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.read_value !== e.read_value) begin
                $error("read_value exp %h got %h", e.read_value, got.read_value); errors++;
            end
            if (got.hblank_irq !== e.hblank_irq) begin
                $error("hblank_irq exp %b got %b", e.hblank_irq, got.hblank_irq); errors++;
            end
            if (got.vblank_irq !== e.vblank_irq) begin
                $error("vblank_irq exp %b got %b", e.vblank_irq, got.vblank_irq); errors++;
            end
            if (got.palette_write !== e.palette_write) begin
                $error("palette_write exp %b got %b", e.palette_write, got.palette_write);
                errors++;
            end
            if (got.palette_index !== e.palette_index) begin
                $error("palette_index exp %h got %h", e.palette_index, got.palette_index);
                errors++;
            end
            if (got.palette_color !== e.palette_color) begin
                $error("palette_color exp %h got %h", e.palette_color, got.palette_color);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_valid, i_ready;
    logic [2:0]  i_kind;
    logic [15:0] i_value;
    logic [8:0]  i_line;
    logic        o_ready, o_valid, o_hblank_irq, o_vblank_irq, o_palette_write;
    logic [15:0] o_read_value;
    logic [5:0]  o_palette_index;
    logic [11:0] o_palette_color;

    port_scoreboard sb;
    int  items_sent;
    bit  send_burst, recv_burst;

    video_port_access_controller i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_value, .i_line,
        .o_valid, .i_ready, .o_read_value, .o_hblank_irq, .o_vblank_irq,
        .o_palette_write, .o_palette_index, .o_palette_color
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_read_value, o_hblank_irq, o_vblank_irq, o_palette_write,
                             o_palette_index, o_palette_color});
    end

    initial begin
        int stall;
        i_ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (($urandom % 64) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_item(logic [2:0] k, logic [15:0] v, logic [8:0] ln);
        int gap;
        if (($urandom % 64) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind  <= k;
        i_value <= v;
        i_line  <= ln;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(k, v, ln);
        items_sent++;
    endtask

    task automatic load_reg(int r, logic [7:0] d);
        send_item(KIND_CTRL, {3'b100, 5'(r), d}, 9'd0);
    endtask

    task automatic set_access(logic [5:0] c, logic [15:0] a, logic [7:0] upper);
        send_item(KIND_CTRL, {c[1:0], a[13:0]}, 9'd0);
        send_item(KIND_CTRL, {upper, c[5:2], 2'b00, a[15:14]}, 9'd0);
    endtask

    function automatic logic [15:0] tame_ctrl(logic [15:0] v);
        if (v[15:14] == 2'b10 && v[12:8] == 5'(REG_LEN_LO)) v[7:0] = 8'($urandom_range(1, 16));
        if (v[15:14] == 2'b10 && v[12:8] == 5'(REG_LEN_HI)) v[7:0] = 8'd0;
        return v;
    endfunction

    initial begin
        int pick, r;
        logic [5:0] c;
        logic [15:0] a;
        logic [5:0] codes [7];
        codes = '{CODE_VRAM_RD, CODE_VRAM_WR, 6'(CODE_CRAM_WR),
                  6'(CODE_SRAM_WR), 6'(CODE_CRAM_RD), 6'(CODE_SRAM_RD), 6'h0B};
        sb = new();
        items_sent = 0;
        send_burst = 0;
        recv_burst = 0;
        i_valid = 0; i_kind = '0; i_value = '0; i_line = '0;
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        send_item(KIND_STATUS, 16'h0, 9'd0);
        send_item(KIND_HV, 16'h0, 9'd0);
        load_reg(31, 8'hFF);
        load_reg(REG_SETUP0, 8'h10);
        load_reg(REG_SETUP1, 8'h38);
        load_reg(REG_HINT, 8'd1);
        send_item(KIND_LINE, 16'h0, 9'd0);
        send_item(KIND_LINE, 16'h0, 9'd240);
        send_item(KIND_STATUS, 16'h0, 9'd0);
        send_item(KIND_LINE, 16'hFFFF, 9'd511);
        set_access(6'(CODE_CRAM_WR), 16'h007E, 8'h00);
        send_item(KIND_WRITE, 16'hFFFF, 9'd0);
        set_access(6'(CODE_SRAM_WR), 16'hFFFE, 8'hFF);
        send_item(KIND_WRITE, 16'h1234, 9'd0);
        set_access(6'h07, 16'hFFFF, 8'h00);
        send_item(KIND_WRITE, 16'hA55A, 9'd0);
        set_access(6'(CODE_CRAM_RD), 16'h007E, 8'h00);
        send_item(KIND_READ, 16'h0, 9'd0);
        set_access(6'h0F, 16'hFFFE, 8'h00);
        send_item(KIND_READ, 16'h0, 9'd0);
        // fill with zero length runs the full 64K bytes
        load_reg(REG_DMA, 8'h80);
        set_access(CODE_DMA | CODE_VRAM_WR, 16'h0001, 8'h00);
        send_item(KIND_WRITE, 16'hC3A5, 9'd0);
        load_reg(REG_LEN_LO, 8'd5);
        load_reg(REG_DMA, 8'hC0);
        set_access(CODE_DMA, 16'h0100, 8'h00);
        load_reg(REG_DMA, 8'h00);
        set_access(CODE_DMA | CODE_VRAM_WR, 16'h0200, 8'h00);
        send_item(KIND_WRITE, 16'h0F0F, 9'd0);
        send_item(KIND_SPARE0, 16'hFFFF, 9'h1FF);
        send_item(KIND_SPARE1, 16'h0000, 9'h000);

        while (items_sent < 1600) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                r = $urandom_range(0, 31);
                send_item(KIND_CTRL, tame_ctrl({3'b100, 5'(r), 8'($urandom)}), 9'd0);
            end else if (pick < 34) begin
                c = codes[$urandom_range(0, 6)];
                if ($urandom_range(0, 3) == 0) c = c | CODE_DMA;
                if ($urandom_range(0, 9) == 0) c = 6'($urandom);
                a = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 127)) : 16'($urandom);
                set_access(c, a, 8'($urandom));
            end else if (pick < 58) begin
                send_item(KIND_WRITE, 16'($urandom), 9'($urandom));
            end else if (pick < 72) begin
                send_item(KIND_READ, 16'($urandom), 9'($urandom));
            end else if (pick < 77) begin
                send_item(KIND_STATUS, 16'($urandom), 9'($urandom));
            end else if (pick < 82) begin
                send_item(KIND_HV, 16'($urandom), 9'($urandom));
            end else if (pick < 96) begin
                send_item(KIND_LINE, 16'($urandom),
                          ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 262)));
            end else if (pick < 98) begin
                send_item(($urandom_range(0, 1) == 0) ? KIND_SPARE0 : KIND_SPARE1,
                          16'($urandom), 9'($urandom));
            end else begin
                send_item(KIND_CTRL, tame_ctrl(16'($urandom)), 9'($urandom));
            end
        end
        @(posedge i_clk);
        i_valid <= 0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d port accesses (register loads, VRAM/CRAM/VSRAM traffic, DMA, lines);",
                 items_sent);
        $display("checked %0d results, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/vpac_pkg.sv
rtl/vpac_ctrl.sv
rtl/vpac_dp.sv
rtl/video_port_access_controller.sv
tb/video_port_access_controller_test.sv
